>>> design/spv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample playback voice package
// Command codes, register map, fixed formats and reset values of the voice.
// ----------------------------------------------------------------------------
package spv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = 12;
	localparam int GAIN_BITS   = 16;
	localparam int ENV_BITS    = 16;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_LOAD  = 2'd0;
	localparam cmd_t CMD_START = 2'd1;
	localparam cmd_t CMD_TICK  = 2'd2;
	localparam cmd_t CMD_STOP  = 2'd3;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_RANGE_BEGIN   = 3'd0;
	localparam reg_idx_t REG_RANGE_END     = 3'd1;
	localparam reg_idx_t REG_LOOP_ENABLE   = 3'd2;
	localparam reg_idx_t REG_PLAYBACK_GAIN = 3'd3;
	localparam reg_idx_t REG_DECAY_FACTOR  = 3'd4;
	localparam reg_idx_t REG_START_DELAY   = 3'd5;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET  = 16'd4096;
	localparam logic [ENV_BITS-1:0]  DECAY_RESET = 16'd32768;
	localparam logic [ENV_BITS-1:0]  ENV_UNITY   = 16'd32768;
	localparam logic [ENV_BITS-1:0]  ENV_FLOOR   = 16'd4;

	localparam int OUT_SHIFT = 27;
	localparam int ENV_SHIFT = 15;

endpackage

>>> design/spv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/sample_playback_voice_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample playback voice
// Sampler voice with waveform store, start delay, loop and exponential decay.
// Load, start and stop requests complete on accept. A frame tick on an idle
// voice or during the start delay gives its result in the cycle after accept.
// An audible tick passes through store read, multiply and round steps, and the
// next request is accepted once its result is registered.
// Reset clears the voice and loads register defaults; the waveform store is
// not cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
module sample_playback_voice_unit #(
	parameter int STORE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // sample_addr[11:0], sample_value[27:12], stop_delay[39:28]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // audio_out[15:0]
	output logic        m_tuser,   // playing[0]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int AB = spv_pkg::ADDR_BITS;
	localparam int SB = spv_pkg::SAMPLE_BITS;
	localparam int EB = spv_pkg::ENV_BITS;
	localparam int PW = 2 * EB;
	localparam int MW = PW + 1 + SB;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_RND  = 2'd2;

	localparam logic signed [MW-1:0] SAT_HI = (MW'(1) <<< (SB - 1)) - MW'(1);
	localparam logic signed [MW-1:0] SAT_LO = -(MW'(1) <<< (SB - 1));
	localparam logic signed [MW-1:0] RND_HALF = MW'(1) <<< (spv_pkg::OUT_SHIFT - 1);

	logic [1:0]             state_q;

	logic [AB-1:0]          cfg_begin_q;
	logic [AB-1:0]          cfg_end_q;
	logic                   cfg_loop_q;
	logic [15:0]            cfg_gain_q;
	logic [15:0]            cfg_decay_q;
	logic [AB-1:0]          cfg_delay_q;

	logic [AB-1:0]          cursor_q;
	logic [AB-1:0]          end_q;
	logic                   loop_q;
	logic [EB-1:0]          env_q;
	logic [AB-1:0]          delay_q;

	logic [PW-1:0]          eg_s1;
	logic [PW-1:0]          ed_s1;
	logic                   inr_s1;
	logic signed [MW-1:0]   p_s2;

	logic                   out_valid_q;
	logic [15:0]            out_audio_q;
	logic                   out_play_q;

	spv_pkg::cmd_t          cmd;
	logic [AB-1:0]          in_addr;
	logic [SB-1:0]          in_value;
	logic [AB-1:0]          in_sdel;
	logic                   acc;
	logic                   out_free;
	logic                   cfg_we;
	spv_pkg::reg_idx_t      cfg_idx;

	logic                   ram_we;
	logic [SB-1:0]          ram_rdata;
	logic signed [SB-1:0]   smp;

	logic [PW:0]            e_sum;
	logic [PW-spv_pkg::ENV_SHIFT:0] e_shr;
	logic [EB-1:0]          env_new;
	logic [AB-1:0]          step;
	logic [AB-1:0]          cur_new;
	logic [AB:0]            lim;
	logic [AB-1:0]          tmp;

	logic signed [MW-1:0]   rnd;
	logic signed [MW-1:0]   y;
	logic [15:0]            y_sat;

	logic                   out_load;
	logic [15:0]            out_audio_d;
	logic                   out_play_d;

	assign cmd      = s_tuser;
	assign in_addr  = s_tdata[11:0];
	assign in_value = s_tdata[27:12];
	assign in_sdel  = s_tdata[39:28];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && ((cmd != spv_pkg::CMD_TICK) || out_free);
	assign acc      = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_audio_q;
	assign m_tuser  = out_play_q;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		case (cfg_idx)
			spv_pkg::REG_RANGE_BEGIN:   prdata = 32'(cfg_begin_q);
			spv_pkg::REG_RANGE_END:     prdata = 32'(cfg_end_q);
			spv_pkg::REG_LOOP_ENABLE:   prdata = 32'(cfg_loop_q);
			spv_pkg::REG_PLAYBACK_GAIN: prdata = 32'(cfg_gain_q);
			spv_pkg::REG_DECAY_FACTOR:  prdata = 32'(cfg_decay_q);
			spv_pkg::REG_START_DELAY:   prdata = 32'(cfg_delay_q);
			default:                    prdata = 32'd0;
		endcase
	end

	// waveform store
	assign ram_we = acc && (cmd == spv_pkg::CMD_LOAD) && (32'(in_addr) < 32'(STORE_DEPTH));

	spv_ram #(
		.WIDTH (SB),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_addr)),
		.wdata (in_value),
		.raddr (AW'(cursor_q)),
		.rdata (ram_rdata)
	);

	assign smp = inr_s1 ? $signed(ram_rdata) : '0;

	// envelope and cursor advance
	assign e_sum   = {1'b0, ed_s1} + (PW+1)'(1 << (spv_pkg::ENV_SHIFT - 1));
	assign e_shr   = e_sum[PW:spv_pkg::ENV_SHIFT];
	assign env_new = (|e_shr[PW-spv_pkg::ENV_SHIFT:EB]) ? {EB{1'b1}} : e_shr[EB-1:0];
	assign step    = (cursor_q < end_q) ? cursor_q + AB'(1) : cursor_q - AB'(1);
	assign cur_new = ((step == end_q) && loop_q) ? cfg_begin_q : step;

	// stop trim
	assign lim = {1'b0, cursor_q} + {1'b0, in_sdel};
	assign tmp = cursor_q - in_sdel;

	// round half up, saturate
	assign rnd   = p_s2 + RND_HALF;
	assign y     = rnd >>> spv_pkg::OUT_SHIFT;
	assign y_sat = (y > SAT_HI) ? 16'(SAT_HI) : (y < SAT_LO) ? 16'(SAT_LO) : y[15:0];

	always_comb begin
		out_load    = 1'b0;
		out_audio_d = y_sat;
		out_play_d  = 1'b1;
		if (state_q == ST_IDLE) begin
			if (acc && (cmd == spv_pkg::CMD_TICK) &&
			    ((cursor_q == end_q) || (delay_q != '0))) begin
				out_load    = 1'b1;
				out_audio_d = 16'd0;
				out_play_d  = (cursor_q != end_q);
			end
		end else if (state_q == ST_RND) begin
			out_load = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_begin_q <= '0;
			cfg_end_q   <= '0;
			cfg_loop_q  <= 1'b0;
			cfg_gain_q  <= spv_pkg::GAIN_RESET;
			cfg_decay_q <= spv_pkg::DECAY_RESET;
			cfg_delay_q <= '0;
			cursor_q    <= '0;
			end_q       <= '0;
			loop_q      <= 1'b0;
			env_q       <= spv_pkg::ENV_UNITY;
			delay_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					spv_pkg::REG_RANGE_BEGIN:   cfg_begin_q <= pwdata[AB-1:0];
					spv_pkg::REG_RANGE_END:     cfg_end_q   <= pwdata[AB-1:0];
					spv_pkg::REG_LOOP_ENABLE:   cfg_loop_q  <= pwdata[0];
					spv_pkg::REG_PLAYBACK_GAIN: cfg_gain_q  <= pwdata[15:0];
					spv_pkg::REG_DECAY_FACTOR:  cfg_decay_q <= pwdata[15:0];
					spv_pkg::REG_START_DELAY:   cfg_delay_q <= pwdata[AB-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (cmd)
							spv_pkg::CMD_START: begin
								cursor_q <= cfg_begin_q;
								end_q    <= cfg_end_q;
								env_q    <= spv_pkg::ENV_UNITY;
								loop_q   <= cfg_loop_q;
								delay_q  <= cfg_delay_q;
							end
							spv_pkg::CMD_STOP: begin
								loop_q <= 1'b0;
								if (cursor_q < end_q) begin
									if (lim < {1'b0, end_q}) begin
										end_q <= lim[AB-1:0];
									end
								end else if ((in_sdel <= cursor_q) && (tmp > end_q)) begin
									end_q <= tmp;
								end
							end
							spv_pkg::CMD_TICK: begin
								if (cursor_q != end_q) begin
									if (delay_q != '0) begin
										delay_q <= delay_q - AB'(1);
									end else begin
										state_q <= ST_MUL;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					env_q    <= env_new;
					cursor_q <= cur_new;
					if (env_new < spv_pkg::ENV_FLOOR) begin
						end_q  <= cur_new;
						loop_q <= 1'b0;
					end
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			eg_s1  <= env_q * cfg_gain_q;
			ed_s1  <= env_q * cfg_decay_q;
			inr_s1 <= (32'(cursor_q) < 32'(STORE_DEPTH));
		end
		if (state_q == ST_MUL) begin
			p_s2 <= $signed({1'b0, eg_s1}) * smp;
		end
		if (out_load) begin
			out_audio_q <= out_audio_d;
			out_play_q  <= out_play_d;
		end
	end

endmodule
